@@ rtl/edvt_pkg.sv @@
// shared types, constants and helpers for the encoder detent value tracker
package edvt_pkg;

  localparam int unsigned VAL_W    = 16;
  localparam int unsigned STEP_W   = 15;
  localparam int unsigned REF_W    = 32;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned DVD_W    = VAL_W + 1;
  localparam int unsigned QUO_W    = DVD_W + 1;
  localparam int unsigned WRK_W    = 24;
  localparam int unsigned PROD_W   = WRK_W + STEP_W + 1;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7fff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = -16'sh8000;

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_LIMIT   = 3'd0,
    REG_MAX_LIMIT   = 3'd1,
    REG_STEP_SIZE   = 3'd2,
    REG_SKIP_ENABLE = 3'd3,
    REG_START_VALUE = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_HI,
    ST_DIV_LO,
    ST_PULL_HI,
    ST_PULL_LO,
    ST_DETENT,
    ST_MUL,
    ST_VALUE
  } state_t;

  typedef struct packed {
    logic                    start;
    logic signed [DVD_W-1:0] dividend;
    logic [STEP_W-1:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(VAL_MAX);
    lo = PROD_W'(VAL_MIN);
    if (v > hi) return VAL_MAX;
    if (v < lo) return VAL_MIN;
    return v[VAL_W-1:0];
  endfunction

endpackage

@@ rtl/encoder_detent_value_tracker_core.sv @@
// encoder detent value tracker: top level with sequencer, datapath and config registers
// a beat runs two divisions by the step size on the shared divider, then the sequencer
//   states that pull the reference, count detents, multiply and form the value
// in_ready only while idle, one beat at a time; a waiting result
//   does not block the next input beat until the following result must be written
// reset: synchronous active low, limits 0, step 1, skip off, start 0, reference and value 0
module encoder_detent_value_tracker_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  in_count_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_setting_value,
  output logic signed [15:0]  out_detents_seen,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import edvt_pkg::*;

  state_t                    state_r, state_nxt;
  logic signed [VAL_W-1:0]   min_r, min_nxt;
  logic signed [VAL_W-1:0]   max_r, max_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic                      skip_r, skip_nxt;
  logic signed [VAL_W-1:0]   start_r, start_nxt;
  logic signed [REF_W-1:0]   ref_r, ref_nxt;
  logic signed [VAL_W-1:0]   cur_r, cur_nxt;
  logic signed [VAL_W-1:0]   cnt_r, cnt_nxt;
  logic signed [QUO_W-1:0]   qhi_r, qhi_nxt;
  logic signed [QUO_W-1:0]   qlo_r, qlo_nxt;
  logic signed [WRK_W-1:0]   wref_r, wref_nxt;
  logic signed [WRK_W-1:0]   det_r, det_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic                      ovld_r, ovld_nxt;
  logic signed [VAL_W-1:0]   oval_r, oval_nxt;
  logic signed [VAL_W-1:0]   odet_r, odet_nxt;

  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  logic signed [WRK_W-1:0]   cnt_w;
  logic signed [WRK_W-1:0]   bound;
  logic signed [WRK_W-1:0]   gap;
  logic signed [WRK_W-1:0]   diff;
  logic signed [WRK_W-1:0]   ref_end;
  logic signed [PROD_W-1:0]  sum;
  logic signed [PROD_W-1:0]  step_w;
  logic                      in_acc;
  logic                      out_free;

  edvt_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_acc   = in_valid && in_ready;
  assign out_free = !ovld_r || out_ready;
  assign cnt_w    = WRK_W'(cnt_r);
  assign step_w   = PROD_W'($signed({1'b0, step_r}));

  always_comb begin
    state_nxt = state_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    step_nxt  = step_r;
    skip_nxt  = skip_r;
    start_nxt = start_r;
    ref_nxt   = ref_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    qhi_nxt   = qhi_r;
    qlo_nxt   = qlo_r;
    wref_nxt  = wref_r;
    det_nxt   = det_r;
    prod_nxt  = prod_r;
    ovld_nxt  = ovld_r && !out_ready;
    oval_nxt  = oval_r;
    odet_nxt  = odet_r;
    bound     = '0;
    gap       = '0;
    diff      = '0;
    ref_end   = '0;
    sum       = '0;
    in_ready  = (state_r == ST_IDLE);
    div_req.start    = 1'b0;
    div_req.divisor  = step_r;
    div_req.dividend = (state_r == ST_IDLE) ? DVD_W'(max_r) - DVD_W'(cur_r)
                                            : DVD_W'(cur_r) - DVD_W'(min_r);

    if (cfg_we) begin
      case (cfg_index)
        REG_MIN_LIMIT:   min_nxt = $signed(cfg_data);
        REG_MAX_LIMIT:   max_nxt = $signed(cfg_data);
        REG_STEP_SIZE:   step_nxt = cfg_data[STEP_W-1:0];
        REG_SKIP_ENABLE: skip_nxt = cfg_data[0];
        REG_START_VALUE: start_nxt = $signed(cfg_data);
        default: ;
      endcase
      if (cfg_index inside {REG_MIN_LIMIT, REG_MAX_LIMIT, REG_STEP_SIZE,
                            REG_SKIP_ENABLE, REG_START_VALUE}) begin
        ref_nxt = '0;
        cur_nxt = start_nxt;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          div_req.start = 1'b1;
          cnt_nxt       = in_count_sample;
          wref_nxt      = ref_r[WRK_W-1:0];
          state_nxt     = ST_DIV_HI;
        end
      end
      ST_DIV_HI: begin
        if (div_rsp.done) begin
          qhi_nxt       = div_rsp.quotient;
          div_req.start = 1'b1;
          state_nxt     = ST_DIV_LO;
        end
      end
      ST_DIV_LO: begin
        if (div_rsp.done) begin
          qlo_nxt   = div_rsp.quotient;
          state_nxt = ST_PULL_HI;
        end
      end
      ST_PULL_HI: begin
        bound = wref_r + WRK_W'($signed({qhi_r, 2'b00}));
        gap   = cnt_w - bound;
        if (cnt_w > bound) wref_nxt = wref_r + $signed({gap[WRK_W-1:2], 2'b00});
        state_nxt = ST_PULL_LO;
      end
      ST_PULL_LO: begin
        bound = wref_r - WRK_W'($signed({qlo_r, 2'b00}));
        gap   = bound - cnt_w;
        if (cnt_w < bound) wref_nxt = wref_r - $signed({gap[WRK_W-1:2], 2'b00});
        state_nxt = ST_DETENT;
      end
      ST_DETENT: begin
        // truncate toward zero: bias negative differences by three
        diff      = cnt_w - wref_r;
        diff      = diff + $signed({{(WRK_W-2){1'b0}}, {2{diff[WRK_W-1]}}});
        det_nxt   = diff >>> 2;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(det_r) * step_w;
        state_nxt = ST_VALUE;
      end
      ST_VALUE: begin
        if (out_free) begin
          if (skip_r) begin
            sum = PROD_W'(cur_r) + prod_r;
          end else if (det_r > 0) begin
            sum = PROD_W'(cur_r) + step_w;
          end else if (det_r < 0) begin
            sum = PROD_W'(cur_r) - step_w;
          end else begin
            sum = PROD_W'(cur_r);
          end
          ref_end   = wref_r + $signed({det_r[WRK_W-3:0], 2'b00});
          cur_nxt   = sat_val(sum);
          ref_nxt   = REF_W'(ref_end);
          ovld_nxt  = 1'b1;
          oval_nxt  = sat_val(sum);
          odet_nxt  = sat_val(PROD_W'(det_r));
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      min_r   <= '0;
      max_r   <= '0;
      step_r  <= STEP_W'(1);
      skip_r  <= 1'b0;
      start_r <= '0;
      ref_r   <= '0;
      cur_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      step_r  <= step_nxt;
      skip_r  <= skip_nxt;
      start_r <= start_nxt;
      ref_r   <= ref_nxt;
      cur_r   <= cur_nxt;
      ovld_r  <= ovld_nxt;
    end
    cnt_r  <= cnt_nxt;
    qhi_r  <= qhi_nxt;
    qlo_r  <= qlo_nxt;
    wref_r <= wref_nxt;
    det_r  <= det_nxt;
    prod_r <= prod_nxt;
    oval_r <= oval_nxt;
    odet_r <= odet_nxt;
  end

  assign out_valid         = ovld_r;
  assign out_setting_value = oval_r;
  assign out_detents_seen  = odet_r;

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input accepted again before the sample was processed");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV_HI || state_r == ST_DIV_LO))
    else $error("divider finished outside a division phase");

  a_cfg_clears_ref: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && state_r == ST_IDLE && !in_valid && cfg_index == REG_STEP_SIZE)
      |=> (ref_r == '0))
    else $error("configuration write did not clear the reference count");

  a_result_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VALUE && out_free) |=> (out_valid && state_r == ST_IDLE))
    else $error("result not presented when the sample finished");

endmodule

@@ rtl/edvt_div.sv @@
// iterative restoring divider, signed dividend by unsigned step, truncating
module edvt_div (
  input  logic               clk,
  input  logic               rst_n,
  input  edvt_pkg::div_req_t req,
  output edvt_pkg::div_rsp_t rsp
);
  import edvt_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  zero_r, zero_nxt;
  logic [DVD_W-1:0]      quo_r, quo_nxt;
  logic [STEP_W-1:0]     rem_r, rem_nxt;
  logic [STEP_W-1:0]     dsr_r, dsr_nxt;

  logic [STEP_W:0]       trial;
  logic [STEP_W:0]       diff;
  logic                  fits;
  logic signed [QUO_W-1:0] qmag;

  always_comb begin
    trial    = {rem_r, quo_r[DVD_W-1]};
    diff     = trial - {1'b0, dsr_r};
    fits     = trial >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = req.dividend[DVD_W-1];
      zero_nxt = (req.divisor == '0);
      quo_nxt  = req.dividend[DVD_W-1] ? DVD_W'(-req.dividend) : DVD_W'(req.dividend);
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  always_comb begin
    qmag         = $signed({1'b0, quo_r});
    rsp.done     = done_r;
    rsp.quotient = zero_r ? '0 : (neg_r ? -qmag : qmag);
  end

endmodule

@@ sim/edvt_tracker_monitor.sv @@
// channel monitor for the encoder detent value tracker: tracks the setting value and checks results
module edvt_tracker_monitor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_count_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_setting_value,
  input  logic signed [15:0] out_detents_seen,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import edvt_pkg::*;

  localparam longint DETENT_PULSES = 4;

  typedef struct packed {
    logic signed [15:0] setting;
    logic signed [15:0] detents;
  } tracker_result_t;

  logic signed [15:0] min_limit;
  logic signed [15:0] max_limit;
  logic [14:0]        step_size;
  logic               skip_enable;
  logic signed [15:0] reload_value;
  logic signed [31:0] ref_count;
  logic signed [15:0] track_value;

  tracker_result_t expected_results[$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint step_quotient(input longint x);
    if (step_size == '0) return 0;
    return x / longint'(step_size);
  endfunction

  task automatic load_defaults();
    min_limit    = '0;
    max_limit    = '0;
    step_size    = 15'd1;
    skip_enable  = 1'b0;
    reload_value = '0;
    ref_count    = '0;
    track_value  = '0;
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
    bit reload;
    reload = 1'b1;
    case (cfg_reg_t'(idx))
      REG_MIN_LIMIT:   min_limit    = data;
      REG_MAX_LIMIT:   max_limit    = data;
      REG_STEP_SIZE:   step_size    = data[14:0];
      REG_SKIP_ENABLE: skip_enable  = data[0];
      REG_START_VALUE: reload_value = data;
      default:         reload       = 1'b0;
    endcase
    if (reload) begin
      ref_count   = '0;
      track_value = reload_value;
    end
  endtask

  task automatic advance_tracker(input logic signed [15:0] sample, output tracker_result_t res);
    longint cnt;
    longint refc;
    longint span_hi;
    longint span_lo;
    longint det;
    longint val;
    cnt  = longint'(sample);
    refc = longint'(ref_count);
    span_hi = refc + step_quotient(longint'(max_limit) - longint'(track_value)) * DETENT_PULSES;
    if (cnt > span_hi) begin
      refc += (cnt - span_hi) / DETENT_PULSES * DETENT_PULSES;
    end
    span_lo = refc - step_quotient(longint'(track_value) - longint'(min_limit)) * DETENT_PULSES;
    if (cnt < span_lo) begin
      refc -= (span_lo - cnt) / DETENT_PULSES * DETENT_PULSES;
    end
    det = (cnt - refc) / DETENT_PULSES;
    val = longint'(track_value);
    if (skip_enable) begin
      val += det * longint'(step_size);
    end else begin
      if (det >= 1) val += longint'(step_size);
      if (det <= -1) val -= longint'(step_size);
    end
    track_value = clamp16(val);
    refc += det * DETENT_PULSES;
    ref_count = refc[31:0];
    res.setting = track_value;
    res.detents = clamp16(det);
  endtask

  always @(posedge clk) begin
    tracker_result_t want;
    if (!rst_n) begin
      load_defaults();
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        write_register(cfg_index, cfg_data);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("beat with nothing expected: value %0d detents %0d",
                                    out_setting_value, out_detents_seen));
        end else begin
          want = expected_results.pop_front();
          if (out_setting_value !== want.setting) begin
            report_mismatch($sformatf("setting_value got %0d expected %0d",
                                      out_setting_value, want.setting));
          end
          if (out_detents_seen !== want.detents) begin
            report_mismatch($sformatf("detents_seen got %0d expected %0d",
                                      out_detents_seen, want.detents));
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_tracker(in_count_sample, want);
        expected_results.push_back(want);
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ sim/encoder_detent_value_tracker_core_tb.sv @@
// testbench top for the encoder detent value tracker: stimulus, settings and verdict
module encoder_detent_value_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import edvt_pkg::*;

  localparam int TOTAL_ITEMS = 1220;
  localparam int CYCLE_LIMIT = 600000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_count_sample;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_setting_value;
  logic signed [15:0] out_detents_seen;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  int fail_count;
  int pending;
  int sender_idle = 19;
  int recv_idle = 51;
  int sent_items = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  encoder_detent_value_tracker_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_count_sample   (in_count_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_setting_value (out_setting_value),
    .out_detents_seen  (out_detents_seen),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  edvt_tracker_monitor u_monitor (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_count_sample   (in_count_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_setting_value (out_setting_value),
    .out_detents_seen  (out_detents_seen),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** encoder_detent_value_tracker_core: FAILED **");
      $finish;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] d_min, input logic [15:0] d_max,
                               input logic [15:0] d_step, input logic [15:0] d_skip,
                               input logic [15:0] d_start, input logic [4:0] mask,
                               input bit stray);
    if (mask[0]) cfg_write(REG_MIN_LIMIT, d_min);
    if (mask[1]) cfg_write(REG_MAX_LIMIT, d_max);
    if (mask[2]) cfg_write(REG_STEP_SIZE, d_step);
    if (mask[3]) cfg_write(REG_SKIP_ENABLE, d_skip);
    if (mask[4]) cfg_write(REG_START_VALUE, d_start);
    // indexes past the last register must not reload anything
    if (stray) cfg_write(3'(REG_START_VALUE) + 3'($urandom_range(1, 3)), 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic send_count(input logic [15:0] c);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_count_sample <= c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_setting();
    logic [15:0] d_min;
    logic [15:0] d_max;
    logic [15:0] d_start;
    logic [14:0] stp;
    logic [4:0]  mask;
    case ($urandom_range(5))
      0: begin
        d_min = -16'($urandom_range(60));
        d_max = 16'($urandom_range(60));
        stp = 15'($urandom_range(1, 4));
        d_start = 16'($urandom_range(120)) - 16'd60;
      end
      1: begin
        d_min = 16'h8000;
        d_max = 16'h7fff;
        stp = 15'($urandom_range(1, 32767));
        d_start = 16'($urandom);
      end
      2: begin
        d_min = 16'($urandom);
        d_max = 16'($urandom);
        stp = 15'($urandom);
        d_start = 16'($urandom);
      end
      3: begin
        d_min = -16'($urandom_range(1000));
        d_max = 16'($urandom_range(1000));
        stp = 15'($urandom_range(1, 50));
        d_start = 16'($urandom_range(2000)) - 16'd1000;
      end
      4: begin
        d_min = -16'($urandom_range(200));
        d_max = 16'($urandom_range(200));
        stp = '0;
        d_start = 16'($urandom_range(400)) - 16'd200;
      end
      default: begin
        d_min = 16'h8000;
        d_max = 16'h7fff;
        stp = $urandom_range(1) ? 15'h7fff : 15'd1;
        d_start = $urandom_range(1) ? 16'h7fff : 16'h8000;
      end
    endcase
    mask = ($urandom_range(3) == 0) ? 5'($urandom) : 5'h1f;
    apply_setting(d_min, d_max, {1'($urandom), stp}, 16'($urandom), d_start, mask,
                  $urandom_range(4) == 0);
  endtask

  task automatic random_phase(input int n);
    logic signed [15:0] pos;
    int r;
    pos = $urandom_range(7) == 0 ? 16'($urandom) : '0;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 70) begin
        pos = pos + 16'($urandom_range(12)) - 16'd6;
      end else if (r < 85) begin
        pos = pos + ($urandom_range(1) ? 16'($urandom_range(7, 40)) : -16'($urandom_range(7, 40)));
      end else if (r < 93) begin
        pos = 16'($urandom);
      end else if (r < 97) begin
        pos = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      end
      send_count(pos);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_count_sample = '0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: zero window, one step
    send_count(16'd0);
    send_count(16'd3);
    send_count(16'd4);
    send_count(-16'd5);
    send_count(16'h7fff);
    send_count(16'h8000);
    send_count(16'd4);
    drain_results();

    // full range, largest step, skip on: value saturation
    apply_setting(16'h8000, 16'h7fff, 16'h7fff, 16'd1, 16'd0, 5'h1f, 1'b0);
    send_count(16'd4);
    send_count(-16'd8);
    send_count(16'h7fff);
    send_count(16'h8000);
    drain_results();

    // zero step through the ignored top bit
    apply_setting(-16'd20, 16'd20, 16'h8000, 16'd1, 16'd5, 5'h1f, 1'b0);
    send_count(16'd12);
    send_count(-16'd12);
    send_count(16'd9);
    drain_results();

    // inverted limits
    apply_setting(16'd100, -16'd100, 16'd3, 16'd0, 16'd0, 5'h1f, 1'b0);
    send_count(16'd20);
    send_count(-16'd20);
    send_count(16'd7);
    drain_results();

    // start outside limits
    apply_setting(16'd0, 16'd10, 16'd1, 16'd0, 16'd500, 5'h1f, 1'b0);
    send_count(16'd4);
    send_count(-16'd40);
    drain_results();

    // unknown index only, no reload
    apply_setting('0, '0, '0, '0, '0, 5'h00, 1'b1);
    send_count(16'd8);
    drain_results();

    while (sent_items < TOTAL_ITEMS) begin
      if (sent_items < 400) begin
        sender_idle = 19;
        recv_idle   = 51;
      end else if (sent_items < 800) begin
        sender_idle = 51;
        recv_idle   = 19;
      end else begin
        sender_idle = 0;
        recv_idle   = 0;
      end
      random_setting();
      random_phase($urandom_range(10, 60));
      drain_results();
    end

    repeat (60) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** encoder_detent_value_tracker_core: PASSED **");
    end else begin
      $display("** encoder_detent_value_tracker_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ encoder_detent_value_tracker_core.f @@
rtl/edvt_pkg.sv
rtl/edvt_div.sv
rtl/encoder_detent_value_tracker_core.sv
sim/edvt_tracker_monitor.sv
sim/encoder_detent_value_tracker_core_tb.sv
